@@ design/rpq_pkg.sv @@
// Shared types, widths and constants of the redmean palette quantiser.
// No dependencies; imported by every module of the block.
package rpq_pkg;

    localparam int COLOR_W    = 8;
    localparam int ENTRY_W    = 3 * COLOR_W;
    localparam int PAIR_W     = 2 * ENTRY_W;
    localparam int PAIR_REGS  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int COUNT_W    = 4;
    localparam int IDX_W      = 3;
    localparam int TREE_SLOTS = 8;

    // Arithmetic widths of the distance lane.
    localparam int RM_W     = COLOR_W;
    localparam int SQ_W     = 2 * COLOR_W;
    localparam int WEIGHT_W = 10;
    localparam int PROD_W   = WEIGHT_W + SQ_W;
    localparam int TERM_W   = PROD_W - 8;
    localparam int DIST_W   = TERM_W + 2;

    // Pipeline depth: four distance stages and three comparison levels.
    localparam int LANE_STAGES = 4;
    localparam int TREE_STAGES = 3;
    localparam int PIPE_STAGES = LANE_STAGES + TREE_STAGES;

    localparam logic [WEIGHT_W-1:0] RED_BASE  = WEIGHT_W'(512);
    localparam logic [WEIGHT_W-1:0] BLUE_BASE = WEIGHT_W'(767);

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_PAIR_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_PAIR_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_PAIR_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_PAIR_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COUNT  = CFG_IDX_W'(4);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_adv_t;

    typedef struct packed {
        logic t1;
        logic t2;
        logic t3;
    } tree_adv_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  index;
        logic              live;
    } cand_t;

    // The lower-index candidate a keeps the place unless b is live and strictly nearer.
    function automatic cand_t pick_nearer(input cand_t a, input cand_t b);
        cand_t res;
        if (b.live && (b.distance < a.distance))
        begin
            res = b;
        end
        else
        begin
            res = a;
        end
        return res;
    endfunction

endpackage

@@ design/rpq_palette_regs.sv @@
// Palette and entry count registers with their write decode.
// Depends on rpq_pkg.
module rpq_palette_regs
    import rpq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]    cfg_data,
    output logic [ENTRY_W-1:0]   entry [PALETTE_ENTRIES],
    output logic [TREE_SLOTS-1:0] live_mask
);

    logic [PAIR_REGS-1:0] pair_we;
    logic                 count_we;
    logic [COUNT_W-1:0]   count_reg;
    logic [ENTRY_W-1:0]   entry_reg [PALETTE_ENTRIES];

    always_comb
    begin
        pair_we  = '0;
        count_we = 1'b0;
        case (cfg_index)
            REG_PALETTE_PAIR_0: pair_we[0] = cfg_valid;
            REG_PALETTE_PAIR_1: pair_we[1] = cfg_valid;
            REG_PALETTE_PAIR_2: pair_we[2] = cfg_valid;
            REG_PALETTE_PAIR_3: pair_we[3] = cfg_valid;
            REG_PALETTE_COUNT:  count_we   = cfg_valid;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else if (count_we)
        begin
            count_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    for (genvar g = 0; g < PALETTE_ENTRIES; g++)
    begin : g_entry
        localparam int PAIR_SEL = g / 2;
        localparam int HALF_LO  = (g % 2) * ENTRY_W;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                entry_reg[g] <= '0;
            end
            else if (pair_we[PAIR_SEL])
            begin
                entry_reg[g] <= cfg_data[HALF_LO +: ENTRY_W];
            end
        end

        assign entry[g] = entry_reg[g];
    end

    // Entry 0 is always searched; a count above the palette size saturates.
    always_comb
    begin
        for (int i = 0; i < TREE_SLOTS; i++)
        begin
            live_mask[i] = (i == 0) ||
                           ((i < PALETTE_ENTRIES) && (count_reg > COUNT_W'(i)));
        end
    end

endmodule

@@ design/rpq_distance_lane.sv @@
// One redmean distance lane: difference, square, weight and sum stages.
// Depends on rpq_pkg.
module rpq_distance_lane
    import rpq_pkg::*;
(
    input  logic               clk,
    input  lane_adv_t          adv,
    input  logic [COLOR_W-1:0] red,
    input  logic [COLOR_W-1:0] green,
    input  logic [COLOR_W-1:0] blue,
    input  logic [ENTRY_W-1:0] entry,
    output logic [DIST_W-1:0]  distance
);

    logic [COLOR_W-1:0]  pal_r, pal_g, pal_b;
    logic [COLOR_W:0]    red_sum;
    logic [COLOR_W-1:0]  dr_next, dg_next, db_next;
    logic [RM_W-1:0]     rm_next;
    logic [COLOR_W-1:0]  dr_reg, dg_reg, db_reg;
    logic [RM_W-1:0]     rm_reg;

    logic [SQ_W-1:0]     dr_sq_reg, dg_sq_reg, db_sq_reg;
    logic [WEIGHT_W-1:0] wr_reg, wb_reg;

    logic [PROD_W-1:0]   red_prod, blue_prod;
    logic [TERM_W-1:0]   rc_reg, gc_reg, bc_reg;

    logic [DIST_W-1:0]   dist_reg;

    assign pal_r = entry[ENTRY_W-1 -: COLOR_W];
    assign pal_g = entry[2*COLOR_W-1 -: COLOR_W];
    assign pal_b = entry[COLOR_W-1:0];

    always_comb
    begin
        red_sum = {1'b0, red} + {1'b0, pal_r};
        rm_next = red_sum[COLOR_W:1];
        dr_next = (red   > pal_r) ? red   - pal_r : pal_r - red;
        dg_next = (green > pal_g) ? green - pal_g : pal_g - green;
        db_next = (blue  > pal_b) ? blue  - pal_b : pal_b - blue;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            dr_reg <= dr_next;
            dg_reg <= dg_next;
            db_reg <= db_next;
            rm_reg <= rm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            dr_sq_reg <= SQ_W'(dr_reg) * SQ_W'(dr_reg);
            dg_sq_reg <= SQ_W'(dg_reg) * SQ_W'(dg_reg);
            db_sq_reg <= SQ_W'(db_reg) * SQ_W'(db_reg);
            wr_reg    <= RED_BASE + WEIGHT_W'(rm_reg);
            wb_reg    <= BLUE_BASE - WEIGHT_W'(rm_reg);
        end
    end

    assign red_prod  = PROD_W'(wr_reg) * PROD_W'(dr_sq_reg);
    assign blue_prod = PROD_W'(wb_reg) * PROD_W'(db_sq_reg);

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            rc_reg <= red_prod[PROD_W-1:8];
            gc_reg <= {dg_sq_reg, 2'b00};
            bc_reg <= blue_prod[PROD_W-1:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            dist_reg <= DIST_W'(rc_reg) + DIST_W'(gc_reg) + DIST_W'(bc_reg);
        end
    end

    assign distance = dist_reg;

endmodule

@@ design/rpq_argmin_tree.sv @@
// Registered three-level minimum tree over the eight candidate slots.
// Depends on rpq_pkg.
module rpq_argmin_tree
    import rpq_pkg::*;
(
    input  logic             clk,
    input  tree_adv_t        adv,
    input  cand_t            slot [TREE_SLOTS],
    output logic [IDX_W-1:0] best_index
);

    cand_t            l1_reg [TREE_SLOTS/2];
    cand_t            l2_reg [TREE_SLOTS/4];
    cand_t            best_next;
    logic [IDX_W-1:0] best_reg;

    always_ff @(posedge clk)
    begin
        if (adv.t1)
        begin
            for (int j = 0; j < TREE_SLOTS/2; j++)
            begin
                l1_reg[j] <= pick_nearer(slot[2*j], slot[2*j+1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.t2)
        begin
            for (int j = 0; j < TREE_SLOTS/4; j++)
            begin
                l2_reg[j] <= pick_nearer(l1_reg[2*j], l1_reg[2*j+1]);
            end
        end
    end

    assign best_next = pick_nearer(l2_reg[0], l2_reg[1]);

    always_ff @(posedge clk)
    begin
        if (adv.t3)
        begin
            best_reg <= best_next.index;
        end
    end

    assign best_index = best_reg;

endmodule

@@ design/redmean_palette_quantizer.sv @@
// Top level of the redmean nearest-palette quantiser.
// Depends on rpq_pkg, rpq_palette_regs, rpq_distance_lane and rpq_argmin_tree.
//
// Usage
// -----
// Each input item is one RGB pixel (red, green, blue) offered with in_valid;
// it is accepted at a rising edge where in_valid is high and in_stall is low.
// Each result item is best_index, the palette entry nearest to the pixel by
// the redmean weighted distance, offered with out_valid and taken at an edge
// where out_valid is high and out_stall is low. On equal distances the lower
// index wins; entry 0 and the first palette_count entries alone are searched.
// The configuration channel (cfg_valid, cfg_index, cfg_data) is always ready and
// the user must write it only while no item is in flight; nothing enforces it.
// The item passes seven register stages on its way to the result; one item is
// accepted every cycle unless the receiver stalls and every stage is full.
// The stages are the distance lanes, one per palette entry (difference,
// square, weight, sum), and a three-level tree.
// A stalled receiver freezes only the full stages: empty stages go on
// filling, and in_stall rises only once every stage holds an item.
// Reset empties the pipeline, clears the palette to black and sets the count
// to eight.
module redmean_palette_quantizer
    import rpq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Pixel channel.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [COLOR_W-1:0]   red,
    input  logic [COLOR_W-1:0]   green,
    input  logic [COLOR_W-1:0]   blue,
    // Result channel.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [IDX_W-1:0]     best_index,
    // Configuration write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PAIR_W-1:0]    cfg_data
);

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES:0]   adv;
    lane_adv_t              lane_adv;
    tree_adv_t              tree_adv;

    logic [ENTRY_W-1:0]    entry [PALETTE_ENTRIES];
    logic [TREE_SLOTS-1:0] live_mask;
    logic [DIST_W-1:0]     dist_lane [PALETTE_ENTRIES];
    cand_t                 slot [TREE_SLOTS];

    logic in_acc;
    logic out_acc;

    assign cfg_ready = 1'b1;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        adv[PIPE_STAGES] = !out_stall;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[PIPE_STAGES-1];
    assign in_acc    = in_valid && !in_stall;
    assign out_acc   = out_valid && !out_stall;

    assign lane_adv = '{s1: adv[0], s2: adv[1], s3: adv[2], s4: adv[3]};
    assign tree_adv = '{t1: adv[4], t2: adv[5], t3: adv[6]};

    rpq_palette_regs #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .entry     (entry),
        .live_mask (live_mask)
    );

    for (genvar g = 0; g < PALETTE_ENTRIES; g++)
    begin : g_lane
        rpq_distance_lane u_lane (
            .clk      (clk),
            .adv      (lane_adv),
            .red      (red),
            .green    (green),
            .blue     (blue),
            .entry    (entry[g]),
            .distance (dist_lane[g])
        );
    end

    // Slots beyond the palette size never win; the palette count itself is
    // applied through the live mask, which is static while items flow.
    for (genvar s = 0; s < TREE_SLOTS; s++)
    begin : g_slot
        if (s < PALETTE_ENTRIES)
        begin : g_used
            assign slot[s] = '{distance: dist_lane[s], index: IDX_W'(s),
                               live: live_mask[s]};
        end
        else
        begin : g_unused
            assign slot[s] = '{distance: '0, index: IDX_W'(s), live: 1'b0};
        end
    end

    rpq_argmin_tree u_tree (
        .clk        (clk),
        .adv        (tree_adv),
        .slot       (slot),
        .best_index (best_index)
    );

`ifndef SYNTHESIS
    // The input is held off only when every stage is full and the output waits.
    a_stall_only_when_full : assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
        else $error("input stalled while the pipeline has a free stage");

    // Items are neither lost nor invented inside the pipeline.
    a_item_count : assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(valid_reg) + int'($past(out_acc)) ==
             $past($countones(valid_reg)) + int'($past(in_acc))))
        else $error("pipeline item count does not balance");

    // A delivered index always names an entry that is searched.
    a_index_in_use : assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> live_mask[best_index])
        else $error("result names a palette entry outside the count");
`endif

endmodule

@@ test/tb_redmean_palette_quantizer.sv @@
// Self-checking testbench of redmean_palette_quantizer: directed probes, then random phases.
// Depends on rpq_pkg and the design; results are checked against a nearest-entry predictor.
module tb_redmean_palette_quantizer;
    import rpq_pkg::*;

    localparam int PALETTE_ENTRIES = 8;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 135;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int N_PROBES        = 24;

    // Indexes that decode to no register; writes to them must leave the palette alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_5 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = CFG_IDX_W'(7);

    localparam logic [ENTRY_W-1:0] C_BLACK   = 24'h000000;
    localparam logic [ENTRY_W-1:0] C_WHITE   = 24'hFFFFFF;
    localparam logic [ENTRY_W-1:0] C_RED     = 24'hFF0000;
    localparam logic [ENTRY_W-1:0] C_GREEN   = 24'h00FF00;
    localparam logic [ENTRY_W-1:0] C_BLUE    = 24'h0000FF;
    localparam logic [ENTRY_W-1:0] C_YELLOW  = 24'hFFFF00;
    localparam logic [ENTRY_W-1:0] C_CYAN    = 24'h00FFFF;
    localparam logic [ENTRY_W-1:0] C_MAGENTA = 24'hFF00FF;

    // Colours used twice each, so that every odd entry ties with the even one below it.
    localparam logic [ENTRY_W-1:0] C_TWIN_A  = 24'h204060;
    localparam logic [ENTRY_W-1:0] C_TWIN_B  = 24'hC08040;
    localparam logic [ENTRY_W-1:0] C_TWIN_C  = 24'h10F0A0;
    localparam logic [ENTRY_W-1:0] C_TWIN_D  = 24'hF01090;

    typedef enum logic [2:0]
    {
        SETUP_KEEP,
        SETUP_PRIMARIES,
        SETUP_COUNT_ZERO,
        SETUP_COUNT_OVER,
        SETUP_COUNT_THREE,
        SETUP_TWINS
    } setup_e;

    typedef struct packed {
        setup_e             setup;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               typed;
        logic [IDX_W-1:0]   idx;
    } probe_t;

    // Directed probes. A row with typed set carries its answer; the rest go to the predictor.
    probe_t probes [N_PROBES] = '{
        // After reset the whole palette is black, so every pixel ties and entry 0 wins.
        '{SETUP_KEEP,        8'h00, 8'h00, 8'h00, 1'b1, 3'd0},
        '{SETUP_KEEP,        8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd0},
        '{SETUP_KEEP,        8'hFF, 8'h00, 8'h80, 1'b1, 3'd0},
        // Eight distinct primaries: an exact match is the only zero distance.
        '{SETUP_PRIMARIES,   8'h00, 8'h00, 8'h00, 1'b1, 3'd0},
        '{SETUP_KEEP,        8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd1},
        '{SETUP_KEEP,        8'hFF, 8'h00, 8'h00, 1'b1, 3'd2},
        '{SETUP_KEEP,        8'h00, 8'hFF, 8'h00, 1'b1, 3'd3},
        '{SETUP_KEEP,        8'h00, 8'h00, 8'hFF, 1'b1, 3'd4},
        '{SETUP_KEEP,        8'hFF, 8'hFF, 8'h00, 1'b1, 3'd5},
        '{SETUP_KEEP,        8'h00, 8'hFF, 8'hFF, 1'b1, 3'd6},
        '{SETUP_KEEP,        8'hFF, 8'h00, 8'hFF, 1'b1, 3'd7},
        '{SETUP_KEEP,        8'h80, 8'h80, 8'h80, 1'b0, 3'd0},
        '{SETUP_KEEP,        8'h01, 8'hFE, 8'h03, 1'b0, 3'd0},
        // A count of zero searches entry 0 alone.
        '{SETUP_COUNT_ZERO,  8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd0},
        '{SETUP_KEEP,        8'h00, 8'hFF, 8'h00, 1'b1, 3'd0},
        // A count above the entry total saturates, so the top entries stay reachable.
        '{SETUP_COUNT_OVER,  8'hFF, 8'h00, 8'hFF, 1'b1, 3'd7},
        '{SETUP_KEEP,        8'h00, 8'hFF, 8'hFF, 1'b1, 3'd6},
        '{SETUP_KEEP,        8'h7F, 8'h80, 8'h81, 1'b0, 3'd0},
        '{SETUP_COUNT_THREE, 8'h00, 8'h00, 8'hFF, 1'b0, 3'd0},
        '{SETUP_KEEP,        8'hFF, 8'hFF, 8'h00, 1'b0, 3'd0},
        // Duplicated entries: the lower index of each pair must win the tie.
        '{SETUP_TWINS,       8'hC0, 8'h80, 8'h40, 1'b1, 3'd2},
        '{SETUP_KEEP,        8'h20, 8'h40, 8'h60, 1'b1, 3'd0},
        '{SETUP_KEEP,        8'hF0, 8'h10, 8'h90, 1'b1, 3'd6},
        '{SETUP_KEEP,        8'h90, 8'h90, 8'h90, 1'b0, 3'd0}
    };

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [COLOR_W-1:0]   red        = '0;
    logic [COLOR_W-1:0]   green      = '0;
    logic [COLOR_W-1:0]   blue       = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [IDX_W-1:0]     best_index;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [PAIR_W-1:0]    cfg_data   = '0;

    // Bench copy of the configuration, updated at each accepted write.
    logic [PAIR_W-1:0]    pal_pair [PAIR_REGS];
    logic [COUNT_W-1:0]   pal_count;

    logic [IDX_W-1:0]     nearest_q [$];
    int                   mismatches  = 0;
    int                   idle_cycles = 0;
    int                   stall_left  = 0;
    bit                   idling      = 1'b0;

    redmean_palette_quantizer #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .best_index (best_index),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic logic [ENTRY_W-1:0] stored_colour(input int k);
        return pal_pair[k / 2][(k % 2) * ENTRY_W +: ENTRY_W];
    endfunction

    // Redmean weighted squared distance, square root left out.
    function automatic int unsigned redmean_dist(input logic [COLOR_W-1:0] r, g, b,
                                                 input logic [ENTRY_W-1:0] pal);
        int unsigned pr, pg, pb, mean_red, ddr, ddg, ddb;
        pr = pal[23:16];
        pg = pal[15:8];
        pb = pal[7:0];
        mean_red = (int'(r) + pr) >> 1;
        ddr = (r > pr) ? r - pr : pr - r;
        ddg = (g > pg) ? g - pg : pg - g;
        ddb = (b > pb) ? b - pb : pb - b;
        return (((int'(RED_BASE) + mean_red) * ddr * ddr) >> 8) + 4 * ddg * ddg
             + (((int'(BLUE_BASE) - mean_red) * ddb * ddb) >> 8);
    endfunction

    // Searches the entries in use from index 0 up; only a strictly smaller distance moves the pick.
    function automatic logic [IDX_W-1:0] nearest_entry(input logic [COLOR_W-1:0] r, g, b);
        int unsigned      span, best_d, d;
        logic [IDX_W-1:0] best;
        span = pal_count;
        if (span < 1)
            span = 1;
        if (span > PALETTE_ENTRIES)
            span = PALETTE_ENTRIES;
        best   = '0;
        best_d = redmean_dist(r, g, b, stored_colour(0));
        for (int k = 1; k < span; k++)
        begin
            d = redmean_dist(r, g, b, stored_colour(k));
            if (d < best_d)
            begin
                best_d = d;
                best   = IDX_W'(k);
            end
        end
        return best;
    endfunction

    function automatic int pick_span();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(0, 2);
        else if (roll < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // Moves each component of a colour by a few steps, clipped to the 8-bit range.
    function automatic logic [ENTRY_W-1:0] nudge_colour(input logic [ENTRY_W-1:0] c);
        logic [ENTRY_W-1:0] res;
        int                 v;
        for (int s = 0; s < 3; s++)
        begin
            v = int'(c[s * COLOR_W +: COLOR_W]) + $urandom_range(0, 8) - 4;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            res[s * COLOR_W +: COLOR_W] = COLOR_W'(v);
        end
        return res;
    endfunction

    // cfg_valid is left high here so that back-to-back writes never toggle it within a step;
    // the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PALETTE_PAIR_0: pal_pair[0] = data;
            REG_PALETTE_PAIR_1: pal_pair[1] = data;
            REG_PALETTE_PAIR_2: pal_pair[2] = data;
            REG_PALETTE_PAIR_3: pal_pair[3] = data;
            REG_PALETTE_COUNT:  pal_count   = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // Registers are only written with the pipeline empty.
    task automatic drain();
        in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [COLOR_W-1:0] r, g, b, input bit typed,
                              input logic [IDX_W-1:0] typed_idx, input bit hold);
        int gap;
        gap = (idling && $urandom_range(0, 1)) ? pick_span() : 0;
        if (hold)
            gap = gap + 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
            // The hold-off waits until the block has handed back every item.
            if (hold)
                while (nearest_q.size() != 0)
                    @(posedge clk);
        end
        in_valid <= 1'b1;
        red      <= r;
        green    <= g;
        blue     <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        nearest_q.push_back(typed ? typed_idx : nearest_entry(r, g, b));
    endtask

    task automatic apply_setup(input setup_e s);
        drain();
        case (s)
            SETUP_PRIMARIES:
            begin
                write_reg(REG_PALETTE_PAIR_0, {C_WHITE, C_BLACK});
                write_reg(REG_PALETTE_PAIR_1, {C_GREEN, C_RED});
                write_reg(REG_PALETTE_PAIR_2, {C_YELLOW, C_BLUE});
                write_reg(REG_PALETTE_PAIR_3, {C_MAGENTA, C_CYAN});
                write_reg(REG_PALETTE_COUNT, PAIR_W'(8));
            end
            SETUP_COUNT_ZERO:
                write_reg(REG_PALETTE_COUNT, PAIR_W'(0));
            // Every bit set: the bits above the count are dropped, leaving fifteen.
            SETUP_COUNT_OVER:
                write_reg(REG_PALETTE_COUNT, {PAIR_W{1'b1}});
            SETUP_COUNT_THREE:
                write_reg(REG_PALETTE_COUNT, PAIR_W'(3));
            SETUP_TWINS:
            begin
                write_reg(REG_PALETTE_PAIR_0, {C_TWIN_A, C_TWIN_A});
                write_reg(REG_PALETTE_PAIR_1, {C_TWIN_B, C_TWIN_B});
                write_reg(REG_PALETTE_PAIR_2, {C_TWIN_C, C_TWIN_C});
                write_reg(REG_PALETTE_PAIR_3, {C_TWIN_D, C_TWIN_D});
                write_reg(REG_PALETTE_COUNT, PAIR_W'(8));
                write_reg(REG_UNUSED_5, {PAIR_W{1'b1}});
                write_reg(REG_UNUSED_6, PAIR_W'(0));
                write_reg(REG_UNUSED_7, {PAIR_W / 2{2'b10}});
            end
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Result checker: every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        logic [IDX_W-1:0] want_index;
        if (rst_n && out_valid && !out_stall)
        begin
            if (nearest_q.size() == 0)
            begin
                report_mismatch($sformatf("best_index %0d with no pixel outstanding",
                                          best_index));
            end
            else
            begin
                want_index = nearest_q.pop_front();
                if (best_index !== want_index)
                    report_mismatch($sformatf("best_index %0d, predicted %0d",
                                              best_index, want_index));
            end
        end
    end

    // Receiver back-pressure: runs of stall and free cycles, mostly short.
    always @(posedge clk)
    begin
        if (!idling)
        begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left = pick_span();
        end
    end

    // Watchdog on cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("redmean_palette_quantizer verification failed");
        $finish;
    end

    initial
    begin
        int                 sel, k, hold_at, items;
        logic [ENTRY_W-1:0] lo, hi, pix;

        for (k = 0; k < PAIR_REGS; k++)
            pal_pair[k] = '0;
        pal_count = COUNT_RESET;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs without idling on the result side, but with sender gaps off too.
        for (int p = 0; p < N_PROBES; p++)
        begin
            if (probes[p].setup != SETUP_KEEP)
                apply_setup(probes[p].setup);
            send_pixel(probes[p].r, probes[p].g, probes[p].b, probes[p].typed,
                       probes[p].idx, 1'b0);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            // The first random phase is a stretch with no idling at all.
            idling = (phase != 0);
            for (k = 0; k < PAIR_REGS; k++)
            begin
                lo  = ENTRY_W'($urandom);
                sel = $urandom_range(0, 3);
                if (sel == 0)
                    hi = lo;
                else if (sel == 1)
                    hi = nudge_colour(lo);
                else
                    hi = ENTRY_W'($urandom);
                write_reg(CFG_IDX_W'(REG_PALETTE_PAIR_0 + k), {hi, lo});
            end
            case (phase)
                0:       write_reg(REG_PALETTE_COUNT, PAIR_W'(8));
                1:       write_reg(REG_PALETTE_COUNT, PAIR_W'(1));
                2:       write_reg(REG_PALETTE_COUNT, PAIR_W'(0));
                3:       write_reg(REG_PALETTE_COUNT, PAIR_W'(15));
                default: write_reg(REG_PALETTE_COUNT, PAIR_W'({$urandom, $urandom}));
            endcase
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_5, REG_UNUSED_7)),
                          PAIR_W'({$urandom, $urandom}));
            cfg_valid <= 1'b0;

            hold_at = $urandom_range(0, PHASE_ITEMS - 1);
            items   = PHASE_ITEMS;
            for (int n = 0; n < items; n++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 5)
                    pix = ENTRY_W'($urandom);
                else if (sel < 8)
                    pix = nudge_colour(stored_colour($urandom_range(0, PALETTE_ENTRIES - 1)));
                else if (sel == 8)
                    pix = stored_colour($urandom_range(0, PALETTE_ENTRIES - 1));
                else
                    pix = {{COLOR_W{1'($urandom)}}, {COLOR_W{1'($urandom)}},
                           {COLOR_W{1'($urandom)}}};
                send_pixel(pix[23:16], pix[15:8], pix[7:0], 1'b0, '0, (n == hold_at));
            end
        end

        in_valid <= 1'b0;
        while (nearest_q.size() != 0)
            @(posedge clk);
        // Let any stray result show up after the last expected one.
        repeat (PIPE_STAGES + 4)
            @(posedge clk);
        if (mismatches == 0)
            $display("redmean_palette_quantizer verification clean");
        else
            $display("redmean_palette_quantizer verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/rpq_pkg.sv
design/rpq_palette_regs.sv
design/rpq_distance_lane.sv
design/rpq_argmin_tree.sv
design/redmean_palette_quantizer.sv
test/tb_redmean_palette_quantizer.sv
